// ----- rtl/rlsd_pkg.sv -----
`default_nettype none

package rlsd_pkg;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_LENGTH = 4'b0010,
		PH_OFFSET = 4'b0100,
		PH_IDLE   = 4'b1000
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_UNTERMINATED = 4'd1,
		ST_TOO_WIDE     = 4'd2,
		ST_SPARSE       = 4'd3,
		ST_TRUNCATED    = 4'd4,
		ST_ZERO_LENGTH  = 4'd5,
		ST_NEGATIVE     = 4'd6,
		ST_OVERFLOW     = 4'd7,
		ST_TOO_MANY     = 4'd8
	} status_t;

	// register index is byte address bit 2
	localparam logic       REG_RUN_CAPACITY = 1'b0;
	localparam logic [15:0] CAPACITY_RESET  = 16'd1024;
	localparam logic [3:0]  FIELD_MAX       = 4'd8;

	localparam int unsigned OUT_DATA_W = 152;

endpackage

`default_nettype wire

// ----- rtl/runlist_stream_decoder_core.sv -----
`default_nettype none

// Mapping-pairs runlist decoder. Bytes enter on the s_ stream (tuser high marks the end of
// a buffer) and each completed run leaves on the m_ stream with its absolute start cluster,
// its length and the running count; a list ends with one status item flagged by tlast.
// The block takes one byte per clock unless a held result stalls it, via an input register
// and a result register; the rate is set by the run completion path, which sign-extends the
// offset, moves the cluster address and checks the run end. There is no clearing
// pass after reset. run_capacity (APB offset 0x0) should only be written while the stream
// is idle. Addresses are CLUSTER_BITS wide and are reported zero-extended to 64 bits.
module runlist_stream_decoder_core #(
	parameter int unsigned CLUSTER_BITS = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,

	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // data_byte
	input  wire logic         s_tuser,   // kind

	output logic              m_tvalid,
	input  wire logic         m_tready,
	// start_cluster[63:0], cluster_count[127:64], status[131:128], runs_decoded[147:132]
	output logic [rlsd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic              m_tlast    // result_kind
);

	logic [15:0] cap_q;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  byte_s1;

	rlsd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  lsz_m1_q, lsz_m1_d;
	logic [2:0]  osz_m1_q, osz_m1_d;
	logic [2:0]  idx_q, idx_d;
	logic [63:0] count_q, count_d;
	logic [63:0] delta_q, delta_d;
	logic [CLUSTER_BITS-1:0] cur_q, cur_d;
	logic [15:0] run_q, run_d;

	logic        proc;
	logic        res_load;
	logic        res_kind;
	logic [63:0] res_start;
	logic [63:0] res_count;
	rlsd_pkg::status_t res_status;
	logic [15:0] res_runs;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [63:0] out_start_q;
	logic [63:0] out_count_q;
	rlsd_pkg::status_t out_status_q;
	logic [15:0] out_runs_q;

	logic [3:0]  hdr_lsz;
	logic [3:0]  hdr_osz;
	logic [63:0] delta_full;
	logic [65:0] moved;
	logic [65:0] run_end;
	logic        is_neg;
	logic        is_ovf_move;
	logic        is_ovf_end;

	// configuration port
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == rlsd_pkg::REG_RUN_CAPACITY) begin
			prdata = 32'(cap_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= rlsd_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == rlsd_pkg::REG_RUN_CAPACITY) begin
			cap_q <= pwdata[15:0];
		end
	end

	// handshake
	assign proc     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign hdr_lsz = byte_s1[3:0];
	assign hdr_osz = byte_s1[7:4];

	// offset with the incoming top byte merged and sign-extended
	always_comb begin
		delta_full = delta_q;
		for (int k = 0; k < 8; k++) begin
			if (3'(k) == idx_q) begin
				delta_full[8*k +: 8] = byte_s1;
			end else if (3'(k) > osz_m1_q && byte_s1[7]) begin
				delta_full[8*k +: 8] = 8'hff;
			end
		end
	end

	assign moved       = 66'(cur_q) + 66'($signed(delta_full));
	assign run_end     = 66'(moved[64:0]) + 66'(count_q);
	assign is_neg      = delta_full[63] && moved[65];
	assign is_ovf_move = !delta_full[63] && (|moved[64:CLUSTER_BITS]);
	assign is_ovf_end  = |run_end[65:CLUSTER_BITS];

	always_comb begin
		phase_d    = phase_q;
		lsz_m1_d   = lsz_m1_q;
		osz_m1_d   = osz_m1_q;
		idx_d      = idx_q;
		count_d    = count_q;
		delta_d    = delta_q;
		cur_d      = cur_q;
		run_d      = run_q;
		res_load   = 1'b0;
		res_kind   = 1'b1;
		res_start  = '0;
		res_count  = '0;
		res_status = rlsd_pkg::ST_OK;
		res_runs   = run_q;

		if (proc) begin
			if (kind_s1) begin
				unique case (phase_q)
					rlsd_pkg::PH_HEADER: begin
						res_load   = 1'b1;
						res_status = rlsd_pkg::ST_UNTERMINATED;
					end
					rlsd_pkg::PH_LENGTH, rlsd_pkg::PH_OFFSET: begin
						res_load   = 1'b1;
						res_status = rlsd_pkg::ST_TRUNCATED;
					end
					default: begin
					end
				endcase
				phase_d  = rlsd_pkg::PH_HEADER;
				lsz_m1_d = '0;
				osz_m1_d = '0;
				idx_d    = '0;
				count_d  = '0;
				delta_d  = '0;
				cur_d    = '0;
				run_d    = '0;
			end else begin
				unique case (phase_q)
					rlsd_pkg::PH_HEADER: begin
						priority if (byte_s1 == 8'h00) begin
							res_load   = 1'b1;
							res_status = rlsd_pkg::ST_OK;
							phase_d    = rlsd_pkg::PH_IDLE;
						end else if (hdr_lsz == 4'd0 || hdr_lsz > rlsd_pkg::FIELD_MAX ||
							hdr_osz > rlsd_pkg::FIELD_MAX) begin
							res_load   = 1'b1;
							res_status = rlsd_pkg::ST_TOO_WIDE;
							phase_d    = rlsd_pkg::PH_IDLE;
						end else if (hdr_osz == 4'd0) begin
							res_load   = 1'b1;
							res_status = rlsd_pkg::ST_SPARSE;
							phase_d    = rlsd_pkg::PH_IDLE;
						end else begin
							lsz_m1_d = 3'(hdr_lsz - 4'd1);
							osz_m1_d = 3'(hdr_osz - 4'd1);
							idx_d    = '0;
							count_d  = '0;
							delta_d  = '0;
							phase_d  = rlsd_pkg::PH_LENGTH;
						end
					end
					rlsd_pkg::PH_LENGTH: begin
						for (int k = 0; k < 8; k++) begin
							if (3'(k) == idx_q) begin
								count_d[8*k +: 8] = byte_s1;
							end
						end
						if (idx_q == lsz_m1_q) begin
							idx_d   = '0;
							phase_d = rlsd_pkg::PH_OFFSET;
						end else begin
							idx_d = idx_q + 3'd1;
						end
					end
					rlsd_pkg::PH_OFFSET: begin
						if (idx_q == osz_m1_q) begin
							idx_d    = '0;
							res_load = 1'b1;
							phase_d  = rlsd_pkg::PH_IDLE;
							priority if (count_q == 64'd0) begin
								res_status = rlsd_pkg::ST_ZERO_LENGTH;
							end else if (is_neg) begin
								res_status = rlsd_pkg::ST_NEGATIVE;
							end else if (is_ovf_move || is_ovf_end) begin
								res_status = rlsd_pkg::ST_OVERFLOW;
							end else if (run_q >= cap_q) begin
								res_status = rlsd_pkg::ST_TOO_MANY;
							end else begin
								cur_d     = moved[CLUSTER_BITS-1:0];
								run_d     = run_q + 16'd1;
								phase_d   = rlsd_pkg::PH_HEADER;
								res_kind  = 1'b0;
								res_start = 64'(moved[CLUSTER_BITS-1:0]);
								res_count = count_q;
								res_runs  = run_q + 16'd1;
							end
						end else begin
							for (int k = 0; k < 8; k++) begin
								if (3'(k) == idx_q) begin
									delta_d[8*k +: 8] = byte_s1;
								end
							end
							idx_d = idx_q + 3'd1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rlsd_pkg::PH_HEADER;
			lsz_m1_q <= '0;
			osz_m1_q <= '0;
			idx_q    <= '0;
			count_q  <= '0;
			delta_q  <= '0;
			cur_q    <= '0;
			run_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			lsz_m1_q <= lsz_m1_d;
			osz_m1_q <= osz_m1_d;
			idx_q    <= idx_d;
			count_q  <= count_d;
			delta_q  <= delta_d;
			cur_q    <= cur_d;
			run_q    <= run_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_kind_q   <= res_kind;
			out_start_q  <= res_start;
			out_count_q  <= res_count;
			out_status_q <= res_status;
			out_runs_q   <= res_runs;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_kind_q;
	assign m_tdata  = {4'b0000, out_runs_q, out_status_q, out_count_q, out_start_q};

	a_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> out_status_q == rlsd_pkg::ST_OK)
		else $error("run request with nonzero status");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> out_start_q == 64'd0 && out_count_q == 64'd0)
		else $error("status request carries cluster data");

	a_run_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> out_runs_q != 16'd0 && out_count_q != 64'd0)
		else $error("run request with zero count");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |-> !s_tready && !res_load)
		else $error("input taken while result stalled");

	a_run_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && !res_kind |=> run_q == $past(run_q) + 16'd1)
		else $error("run counter not advanced");

endmodule

`default_nettype wire
